>>> hdl/gsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared constants, word map, access types and a helper function for the
// gpio function select / set / clear register block.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int GSC_PIN_COUNT = 54;
    localparam int WORD_W        = 32;
    localparam int INDEX_W       = 4;
    localparam int FN_WORDS      = 6;
    localparam int FN_SEL_W      = 3;
    localparam int FN_FIELDS     = 10;
    localparam int FN_FIELD_W    = 3;
    localparam int FN_PINS       = FN_WORDS * FN_FIELDS;
    localparam int IN_FIXED_W    = INDEX_W + WORD_W;

    localparam logic [FN_FIELD_W-1:0] FN_OUTPUT_CODE = 3'b001;

    localparam logic ACC_WRITE = 1'b0;
    localparam logic ACC_READ  = 1'b1;

    localparam logic [INDEX_W-1:0] W_FSEL0 = 4'd0;
    localparam logic [INDEX_W-1:0] W_FSEL5 = 4'd5;
    localparam logic [INDEX_W-1:0] W_SET0  = 4'd7;
    localparam logic [INDEX_W-1:0] W_SET1  = 4'd8;
    localparam logic [INDEX_W-1:0] W_CLR0  = 4'd10;
    localparam logic [INDEX_W-1:0] W_CLR1  = 4'd11;
    localparam logic [INDEX_W-1:0] W_LEV0  = 4'd13;
    localparam logic [INDEX_W-1:0] W_LEV1  = 4'd14;

    typedef struct packed {
        logic               is_read;
        logic [INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]  write_data;
    } t_access;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              access_error;
    } t_read_result;

    // bits of function word w that belong to existing pins
    function automatic logic [WORD_W-1:0] fn_field_mask(input int w, input int pin_count);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int k = 0; k < FN_FIELDS; k++) begin
            if (w * FN_FIELDS + k < pin_count) begin
                m[FN_FIELD_W*k +: FN_FIELD_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

>>> hdl/gsc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_in_stage
// Input register for bus accesses: unpacks the stream beat and holds it
// until the register file can take it.
// ----------------------------------------------------------------------------
module gsc_in_stage
    import gsc_pkg::*;
#(
    parameter int PIN_COUNT = GSC_PIN_COUNT,
    parameter int TDATA_W   = ((IN_FIXED_W + PIN_COUNT + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [TDATA_W-1:0]   i_tdata,
    input  logic                 i_tuser,
    input  logic                 i_take,
    output logic                 o_valid,
    output t_access              o_acc,
    output logic [PIN_COUNT-1:0] o_levels
);

    logic                 r_valid;
    t_access              r_acc;
    logic [PIN_COUNT-1:0] r_levels;

    assign o_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_acc.is_read    <= i_tuser;
            r_acc.word_index <= i_tdata[INDEX_W-1:0];
            r_acc.write_data <= i_tdata[INDEX_W +: WORD_W];
            r_levels         <= i_tdata[IN_FIXED_W +: PIN_COUNT];
        end
    end

    assign o_valid  = r_valid;
    assign o_acc    = r_acc;
    assign o_levels = r_levels;

endmodule

>>> hdl/gsc_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_regfile
// Function select words and output latch, word decode, read mux and
// per-pin output enable decode.
// ----------------------------------------------------------------------------
module gsc_regfile
    import gsc_pkg::*;
#(
    parameter int PIN_COUNT = GSC_PIN_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  t_access              i_acc,
    input  logic [PIN_COUNT-1:0] i_levels,
    output t_read_result         o_result,
    output logic [PIN_COUNT-1:0] o_pins_out,
    output logic [PIN_COUNT-1:0] o_output_enable
);

    logic [WORD_W-1:0]    r_fn_words [FN_WORDS];
    logic [WORD_W-1:0]    n_fn_words [FN_WORDS];
    logic [PIN_COUNT-1:0] r_latch;
    logic [PIN_COUNT-1:0] n_latch;
    logic [WORD_W-1:0]    fn_mask [FN_WORDS];
    logic [63:0]          data_lo;
    logic [63:0]          data_hi;
    logic [63:0]          levels64;
    logic [FN_SEL_W-1:0]  sel;
    t_read_result         result;

    for (genvar w = 0; w < FN_WORDS; w++) begin : g_mask
        assign fn_mask[w] = fn_field_mask(w, PIN_COUNT);
    end

    assign data_lo  = 64'(i_acc.write_data);
    assign data_hi  = {i_acc.write_data, 32'd0};
    assign levels64 = 64'(i_levels);
    assign sel      = i_acc.word_index[FN_SEL_W-1:0];

    always_comb begin
        n_fn_words = r_fn_words;
        n_latch    = r_latch;
        result     = '0;
        if (i_acc.is_read == ACC_READ) begin
            case (i_acc.word_index) inside
                [W_FSEL0:W_FSEL5]: begin
                    result.read_data = r_fn_words[sel];
                end
                W_LEV0: begin
                    result.read_data = levels64[31:0];
                end
                W_LEV1: begin
                    result.read_data = levels64[63:32];
                end
                W_SET0, W_SET1, W_CLR0, W_CLR1: begin
                    result.read_data = '0;
                end
                default: begin
                    result.access_error = 1'b1;
                end
            endcase
        end else begin
            case (i_acc.word_index) inside
                [W_FSEL0:W_FSEL5]: begin
                    n_fn_words[sel] = i_acc.write_data & fn_mask[sel];
                end
                W_SET0: begin
                    n_latch = r_latch | data_lo[PIN_COUNT-1:0];
                end
                W_SET1: begin
                    n_latch = r_latch | data_hi[PIN_COUNT-1:0];
                end
                W_CLR0: begin
                    n_latch = r_latch & ~data_lo[PIN_COUNT-1:0];
                end
                W_CLR1: begin
                    n_latch = r_latch & ~data_hi[PIN_COUNT-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < FN_WORDS; w++) begin
                r_fn_words[w] <= '0;
            end
            r_latch <= '0;
        end else if (i_advance) begin
            r_fn_words <= n_fn_words;
            r_latch    <= n_latch;
        end
    end

    // enables follow the words as they stand after this access
    for (genvar p = 0; p < PIN_COUNT; p++) begin : g_oe
        if (p < FN_PINS) begin : g_field
            assign o_output_enable[p] =
                n_fn_words[p / FN_FIELDS][FN_FIELD_W*(p % FN_FIELDS) +: FN_FIELD_W]
                == FN_OUTPUT_CODE;
        end else begin : g_none
            assign o_output_enable[p] = 1'b0;
        end
    end

    assign o_pins_out = n_latch;
    assign o_result   = result;

    a_set_lo : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_acc.is_read == ACC_WRITE && i_acc.word_index == W_SET0
        |=> (r_latch & $past(data_lo[PIN_COUNT-1:0])) == $past(data_lo[PIN_COUNT-1:0]))
        else $error("set of low word did not reach the latch");

    a_read_keeps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_acc.is_read == ACC_READ |=> $stable(r_latch))
        else $error("read access changed the output latch");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.access_error |-> i_acc.is_read == ACC_READ && result.read_data == '0)
        else $error("error flagged on a write or with non-zero data");

    a_unused_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fn_words[FN_WORDS-1] & ~fn_mask[FN_WORDS-1]) == '0)
        else $error("function word holds bits of absent pins");

endmodule

>>> hdl/gsc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_out_stage
// Result register: packs read data, latch and enables into the outgoing
// beat and holds it while the receiver stalls.
// ----------------------------------------------------------------------------
module gsc_out_stage
    import gsc_pkg::*;
#(
    parameter int PIN_COUNT = GSC_PIN_COUNT,
    parameter int TDATA_W   = ((WORD_W + 2 * PIN_COUNT + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_free,
    input  t_read_result         i_result,
    input  logic [PIN_COUNT-1:0] i_pins_out,
    input  logic [PIN_COUNT-1:0] i_output_enable,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [TDATA_W-1:0]   o_tdata,
    output logic                 o_tuser
);

    logic               r_valid;
    logic [TDATA_W-1:0] r_tdata;
    logic               r_tuser;
    logic [TDATA_W-1:0] packed_data;

    assign o_free = !r_valid || i_tready;

    always_comb begin
        packed_data                               = '0;
        packed_data[WORD_W-1:0]                   = i_result.read_data;
        packed_data[WORD_W +: PIN_COUNT]          = i_pins_out;
        packed_data[WORD_W + PIN_COUNT +: PIN_COUNT] = i_output_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_free) begin
            r_tdata <= packed_data;
            r_tuser <= i_result.access_error;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;

endmodule

>>> hdl/gpio_select_set_clear_regs_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_select_set_clear_regs_top
// GPIO register block: function select words, output latch set / clear,
// pad level readback, driven by one bus access per beat.
//
// Each slave beat is one access: tuser gives the kind (0 write, 1 read),
// tdata carries the word index, write data and the sampled pad levels.
// Each access gives exactly one master beat with the read data, the output
// latch and the output enables as they stand after the access; tuser is
// raised for a read of an unmapped word.
// A beat is taken into the input register, decoded and applied as it passes
// into the result register, and offered from there; a stalled receiver can
// hold it in the input register while the result register is full.
// Throughput: one beat per cycle while the receiver keeps m_axis_tready high;
// the only loop is the state update of the select words and latch.
// Reset clears the select words (all pins input), the output latch and both
// stage valids. When the receiver stalls the result register holds, the
// input register fills, and s_axis_tready falls only once both are full.
// ----------------------------------------------------------------------------
module gpio_select_set_clear_regs_top
    import gsc_pkg::*;
#(
    parameter int PIN_COUNT = GSC_PIN_COUNT,
    localparam int S_TDATA_W = ((IN_FIXED_W + PIN_COUNT + 7) / 8) * 8,
    localparam int M_TDATA_W = ((WORD_W + 2 * PIN_COUNT + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // word_index, write_data, pin_levels
    input  logic                 s_axis_tuser,  // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_data, pins_out, output_enable
    output logic                 m_axis_tuser   // access_error
);

    logic                 out_free;
    logic                 in_valid;
    logic                 advance;
    t_access              acc;
    logic [PIN_COUNT-1:0] levels;
    t_read_result         result;
    logic [PIN_COUNT-1:0] pins_out;
    logic [PIN_COUNT-1:0] output_enable;

    assign advance = in_valid && out_free;

    gsc_in_stage #(
        .PIN_COUNT (PIN_COUNT),
        .TDATA_W   (S_TDATA_W)
    ) u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_take   (out_free),
        .o_valid  (in_valid),
        .o_acc    (acc),
        .o_levels (levels)
    );

    gsc_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regfile (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_acc           (acc),
        .i_levels        (levels),
        .o_result        (result),
        .o_pins_out      (pins_out),
        .o_output_enable (output_enable)
    );

    gsc_out_stage #(
        .PIN_COUNT (PIN_COUNT),
        .TDATA_W   (M_TDATA_W)
    ) u_out_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (advance),
        .o_free          (out_free),
        .i_result        (result),
        .i_pins_out      (pins_out),
        .i_output_enable (output_enable),
        .o_tvalid        (m_axis_tvalid),
        .i_tready        (m_axis_tready),
        .o_tdata         (m_axis_tdata),
        .o_tuser         (m_axis_tuser)
    );

endmodule
